### rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned HalfW    = 16;
  localparam int unsigned TimeoutW = 10;
  localparam int unsigned LenW     = 5;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_PUSH  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BUSERR = 2'd1;
  localparam logic [1:0] STATUS_NOACK  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HALF     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 2'd2;

  typedef struct packed {
    logic [7:0]          dev_addr;
    logic [HalfW-1:0]    half_ticks;
    logic [TimeoutW-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;
  } res_t;

endpackage

### rtl/core/i2cm_if.sv
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] reg_address;
  logic [7:0] data_byte;
  logic [4:0] length;
  logic       sda_in;

  modport source (
    output valid, func, reg_address, data_byte, length, sda_in,
    input  ready
  );
  modport sink (
    input  valid, func, reg_address, data_byte, length, sda_in,
    output ready
  );
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       read_last;
  logic       done_res;
  logic [1:0] status;
  logic       busy_res;

  modport source (
    output valid, scl_out, sda_out, read_byte, read_valid, read_last, done_res, status,
           busy_res,
    input  ready
  );
  modport sink (
    input  valid, scl_out, sda_out, read_byte, read_valid, read_last, done_res, status,
           busy_res,
    output ready
  );
endinterface

### rtl/core/i2cm_core.sv
module i2cm_core
  import i2cm_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [1:0]      func_i,
  input  logic [7:0]      reg_address_i,
  input  logic [7:0]      data_byte_i,
  input  logic [LenW-1:0] length_i,
  input  logic            sda_in_i,
  input  cfg_t            cfg_i,
  output res_t            res_o
);

  localparam int unsigned MaxCnt = (BUFFER_DEPTH > 16) ? BUFFER_DEPTH : 16;
  localparam int unsigned CntW   = $clog2(MaxCnt + 1);
  localparam int unsigned CmpW   = (CntW > LenW) ? CntW : LenW;
  localparam int unsigned AddrW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned MaxRead = 16;

  // ceil(h / 5) as ((h + 4) * 104858) >> 19, exact for 17-bit operands
  localparam int unsigned RelW   = HalfW + 1;
  localparam int unsigned ProdW  = 2 * RelW;
  localparam logic [ProdW-1:0] RelMul = ProdW'(104858);
  localparam int unsigned RelShift = 19;

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST_REL   = 5'd1;
  localparam logic [4:0] PH_ST_HIGH  = 5'd2;
  localparam logic [4:0] PH_ST_LOW   = 5'd3;
  localparam logic [4:0] PH_ST_HOLD  = 5'd4;
  localparam logic [4:0] PH_TX_HIGH  = 5'd5;
  localparam logic [4:0] PH_TX_LOW   = 5'd6;
  localparam logic [4:0] PH_ACK_POLL = 5'd7;
  localparam logic [4:0] PH_ACK_HIGH = 5'd8;
  localparam logic [4:0] PH_ACK_LOW  = 5'd9;
  localparam logic [4:0] PH_RX_REL   = 5'd10;
  localparam logic [4:0] PH_RX_HIGH  = 5'd11;
  localparam logic [4:0] PH_RX_LOW   = 5'd12;
  localparam logic [4:0] PH_MA_HIGH  = 5'd13;
  localparam logic [4:0] PH_MA_LOW   = 5'd14;
  localparam logic [4:0] PH_SP_LOW   = 5'd15;
  localparam logic [4:0] PH_SP_HIGH  = 5'd16;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_REG   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_RADDR = 3'd4;

  logic [4:0]          phase_q, phase_d;
  logic [2:0]          stage_q, stage_d;
  logic [3:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic [CntW-1:0]     bc_q, bc_d;
  logic [HalfW-1:0]    delay_q, delay_d;
  logic [TimeoutW-1:0] poll_q, poll_d;
  logic                is_read_q, is_read_d;
  logic [7:0]          sreg_q, sreg_d;
  logic [LenW-1:0]     slen_q, slen_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic [1:0]          end_q, end_d;

  logic [7:0]          mem_q [BUFFER_DEPTH];
  logic [7:0]          rdata_q;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [AddrW-1:0]    mem_raddr;

  logic [HalfW-1:0]    h;
  logic [TimeoutW-1:0] lim;
  logic [RelW-1:0]     rel_sum;
  logic [ProdW-1:0]    rel_prod;
  logic [HalfW-1:0]    rel_ticks;
  logic [CntW-1:0]     bc_inc;
  logic                last_byte;
  logic [TimeoutW:0]   poll_inc;
  logic [3:0]          bit_inc;
  logic [7:0]          rx_shift;

  assign h         = (cfg_i.half_ticks == '0) ? HalfW'(1) : cfg_i.half_ticks;
  assign lim       = (cfg_i.ack_timeout == '0) ? TimeoutW'(1) : cfg_i.ack_timeout;
  assign rel_sum   = {1'b0, h} + RelW'(4);
  assign rel_prod  = ProdW'(rel_sum) * RelMul;
  assign rel_ticks = HalfW'(rel_prod >> RelShift);
  assign bc_inc    = bc_q + CntW'(1);
  assign last_byte = CmpW'(bc_inc) >= CmpW'(slen_q);
  assign poll_inc  = {1'b0, poll_q} + (TimeoutW + 1)'(1);
  assign bit_inc   = bit_q + 4'd1;
  assign rx_shift  = {shift_q[6:0], sda_in_i};

  always_comb begin
    logic            do_tx;
    logic [7:0]      tx_byte;
    logic            do_stop;
    logic [1:0]      stop_st;
    logic            do_start;
    logic            do_rx;
    logic            do_send;
    logic [CntW-1:0] send_bc;

    do_tx    = 1'b0;
    tx_byte  = '0;
    do_stop  = 1'b0;
    stop_st  = STATUS_OK;
    do_start = 1'b0;
    do_rx    = 1'b0;
    do_send  = 1'b0;
    send_bc  = bc_q;

    phase_d   = phase_q;
    stage_d   = stage_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    bc_d      = bc_q;
    delay_d   = delay_q;
    poll_d    = poll_q;
    is_read_d = is_read_q;
    sreg_d    = sreg_q;
    slen_d    = slen_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    end_d     = end_q;
    mem_we    = 1'b0;
    mem_waddr = bc_q[AddrW-1:0];
    res_o     = '0;

    if (step_i) begin
      if (func_i == FUNC_TICK) begin
        if (phase_q == PH_IDLE) begin
          phase_d = PH_IDLE;
        end else if (phase_q == PH_ACK_POLL) begin
          if (!sda_in_i) begin
            phase_d = PH_ACK_HIGH;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            delay_d = h;
          end else begin
            poll_d = poll_inc[TimeoutW-1:0];
            if (poll_inc >= {1'b0, lim}) begin
              do_stop = 1'b1;
              stop_st = STATUS_NOACK;
            end
          end
        end else if (delay_q > HalfW'(1)) begin
          delay_d = delay_q - HalfW'(1);
        end else begin
          unique case (phase_q)
            PH_ST_REL: begin
              phase_d = PH_ST_HIGH;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              delay_d = h;
            end
            PH_ST_HIGH: begin
              if (!sda_in_i) begin
                do_stop = 1'b1;
                stop_st = STATUS_BUSERR;
              end else begin
                phase_d = PH_ST_LOW;
                scl_d   = 1'b1;
                sda_d   = 1'b0;
                delay_d = h;
              end
            end
            PH_ST_LOW: begin
              if (sda_in_i) begin
                do_stop = 1'b1;
                stop_st = STATUS_BUSERR;
              end else begin
                phase_d = PH_ST_HOLD;
                scl_d   = 1'b0;
                sda_d   = 1'b0;
                delay_d = h;
              end
            end
            PH_ST_HOLD: begin
              do_tx = 1'b1;
              if (is_read_q && stage_q == ST_REG) begin
                stage_d = ST_RADDR;
                tx_byte = cfg_i.dev_addr + 8'd1;
              end else begin
                stage_d = ST_ADDR;
                tx_byte = cfg_i.dev_addr;
              end
            end
            PH_TX_HIGH: begin
              phase_d = PH_TX_LOW;
              scl_d   = 1'b0;
              delay_d = h;
            end
            PH_TX_LOW: begin
              bit_d = bit_inc;
              if (bit_inc >= 4'd8) begin
                poll_d  = '0;
                phase_d = PH_ACK_POLL;
                scl_d   = 1'b1;
                sda_d   = 1'b1;
                delay_d = '0;
              end else begin
                shift_d = {shift_q[6:0], 1'b0};
                phase_d = PH_TX_HIGH;
                scl_d   = 1'b1;
                sda_d   = shift_q[6];
                delay_d = h;
              end
            end
            PH_ACK_HIGH: begin
              phase_d = PH_ACK_LOW;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              delay_d = h;
            end
            PH_ACK_LOW: begin
              case (stage_q)
                ST_ADDR: begin
                  stage_d = ST_REG;
                  do_tx   = 1'b1;
                  tx_byte = sreg_q;
                end
                ST_REG: begin
                  if (is_read_q) begin
                    do_start = 1'b1;
                  end else begin
                    do_send = 1'b1;
                  end
                end
                ST_DATA: begin
                  bc_d    = bc_inc;
                  send_bc = bc_inc;
                  do_send = 1'b1;
                end
                default: begin
                  bc_d  = '0;
                  do_rx = 1'b1;
                end
              endcase
            end
            PH_RX_REL: begin
              bit_d   = '0;
              shift_d = '0;
              phase_d = PH_RX_HIGH;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              delay_d = h;
            end
            PH_RX_HIGH: begin
              shift_d = rx_shift;
              bit_d   = bit_inc;
              if (bit_inc >= 4'd8) begin
                res_o.read_byte  = rx_shift;
                res_o.read_valid = 1'b1;
                res_o.read_last  = last_byte;
              end
              phase_d = PH_RX_LOW;
              scl_d   = 1'b0;
              sda_d   = 1'b1;
              delay_d = h;
            end
            PH_RX_LOW: begin
              scl_d   = 1'b1;
              delay_d = h;
              if (bit_q < 4'd8) begin
                phase_d = PH_RX_HIGH;
                sda_d   = 1'b1;
              end else begin
                phase_d = PH_MA_HIGH;
                sda_d   = last_byte;
              end
            end
            PH_MA_HIGH: begin
              phase_d = PH_MA_LOW;
              scl_d   = 1'b0;
              delay_d = h;
            end
            PH_MA_LOW: begin
              bc_d = bc_inc;
              if (last_byte) begin
                do_stop = 1'b1;
                stop_st = STATUS_OK;
              end else begin
                do_rx = 1'b1;
              end
            end
            PH_SP_LOW: begin
              phase_d = PH_SP_HIGH;
              scl_d   = 1'b1;
              sda_d   = 1'b0;
              delay_d = h;
            end
            default: begin
              phase_d        = PH_IDLE;
              scl_d          = 1'b1;
              sda_d          = 1'b1;
              delay_d        = '0;
              res_o.done_res = 1'b1;
              res_o.status   = end_q;
              bc_d           = '0;
              bit_d          = '0;
              stage_d        = ST_NONE;
            end
          endcase
        end
      end else if (phase_q == PH_IDLE) begin
        if (func_i == FUNC_PUSH) begin
          if (bc_q < CntW'(BUFFER_DEPTH)) begin
            mem_we = 1'b1;
            bc_d   = bc_inc;
          end
        end else begin
          is_read_d = (func_i == FUNC_READ);
          sreg_d    = reg_address_i;
          slen_d    = length_i;
          if (func_i == FUNC_READ) begin
            if (length_i == '0) begin
              slen_d = LenW'(1);
            end else if (length_i > LenW'(MaxRead)) begin
              slen_d = LenW'(MaxRead);
            end
          end else if (int'(length_i) > BUFFER_DEPTH) begin
            slen_d = LenW'(BUFFER_DEPTH);
          end
          bc_d     = '0;
          bit_d    = '0;
          poll_d   = '0;
          stage_d  = ST_NONE;
          do_start = 1'b1;
        end
      end

      if (do_send) begin
        if (CmpW'(send_bc) < CmpW'(slen_q)) begin
          stage_d = ST_DATA;
          do_tx   = 1'b1;
          tx_byte = rdata_q;
        end else begin
          do_stop = 1'b1;
          stop_st = STATUS_OK;
        end
      end
      if (do_tx) begin
        shift_d = tx_byte;
        bit_d   = '0;
        phase_d = PH_TX_HIGH;
        scl_d   = 1'b1;
        sda_d   = tx_byte[7];
        delay_d = h;
      end
      if (do_stop) begin
        end_d   = stop_st;
        phase_d = PH_SP_LOW;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        delay_d = h;
      end
      if (do_start) begin
        phase_d = PH_ST_REL;
        sda_d   = 1'b1;
        delay_d = h;
      end
      if (do_rx) begin
        phase_d = PH_RX_REL;
        scl_d   = 1'b0;
        sda_d   = 1'b1;
        delay_d = rel_ticks;
      end
    end

    res_o.scl_out  = scl_d;
    res_o.sda_out  = sda_d;
    res_o.busy_res = (phase_d != PH_IDLE);
  end

  // prefetch the entry the next data byte will come from
  assign mem_raddr = bc_d[AddrW-1:0] + AddrW'(stage_d == ST_DATA);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= data_byte_i;
    end
    if (step_i) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      stage_q   <= ST_NONE;
      bit_q     <= '0;
      shift_q   <= '0;
      bc_q      <= '0;
      delay_q   <= '0;
      poll_q    <= '0;
      is_read_q <= 1'b0;
      sreg_q    <= '0;
      slen_q    <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      end_q     <= STATUS_OK;
    end else begin
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      bc_q      <= bc_d;
      delay_q   <= delay_d;
      poll_q    <= poll_d;
      is_read_q <= is_read_d;
      sreg_q    <= sreg_d;
      slen_q    <= slen_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      end_q     <= end_d;
    end
  end

endmodule

### rtl/core/i2c_master_register_access_unit.sv
// channel   dir  handshake      payload
// req_if    in   valid/ready    func, reg_address, data_byte, length, sda_in
// res_if    out  valid/ready    scl_out, sda_out, read_byte, read_valid, read_last,
//                               done_res, status, busy_res
// cfg       in   cfg_we_i       cfg_index_i, cfg_wdata_i
//
// one request is taken per cycle; its result is in the output register on the next cycle
// a request is taken while a result waits, as long as that result leaves in the same cycle
// each request is one state machine tick, or a command that is applied only while idle
// rst_ni clears the state machine and output valid; the config registers take defaults
// the write buffer is not cleared; its entries are defined once pushed
module i2c_master_register_access_unit
  import i2cm_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2cm_req_if.sink           req_if,
  i2cm_res_if.source         res_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  cfg_t cfg_q;
  res_t res_d;
  res_t res_q;
  logic valid_q;
  logic step;

  assign req_if.ready = !valid_q || res_if.ready;
  assign step         = req_if.valid && req_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= 8'd180;
      cfg_q.half_ticks  <= HalfW'(5);
      cfg_q.ack_timeout <= TimeoutW'(500);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEV_ADDR: cfg_q.dev_addr    <= cfg_wdata_i[7:0];
        CFG_HALF:     cfg_q.half_ticks  <= cfg_wdata_i[HalfW-1:0];
        CFG_TIMEOUT:  cfg_q.ack_timeout <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  i2cm_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .func_i        (req_if.func),
    .reg_address_i (req_if.reg_address),
    .data_byte_i   (req_if.data_byte),
    .length_i      (req_if.length),
    .sda_in_i      (req_if.sda_in),
    .cfg_i         (cfg_q),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (step) begin
      valid_q <= 1'b1;
    end else if (res_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_if.valid      = valid_q;
  assign res_if.scl_out    = res_q.scl_out;
  assign res_if.sda_out    = res_q.sda_out;
  assign res_if.read_byte  = res_q.read_byte;
  assign res_if.read_valid = res_q.read_valid;
  assign res_if.read_last  = res_q.read_last;
  assign res_if.done_res   = res_q.done_res;
  assign res_if.status     = res_q.status;
  assign res_if.busy_res   = res_q.busy_res;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && res_if.done_res |-> !res_if.busy_res)
    else $error("done result still busy");

  a_rx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && res_if.read_valid |-> res_if.busy_res && !res_if.done_res)
    else $error("received byte outside a transaction");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && res_if.status != STATUS_OK |-> res_if.done_res)
    else $error("status without done");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid && !res_if.ready |-> !req_if.ready)
    else $error("request taken over a stalled result");

endmodule

### test/tb_i2c_master_register_access_unit.sv
`timescale 1ns / 1ps

module tb_i2c_master_register_access_unit;
  import i2cm_pkg::*;

  localparam int BUF_DEPTH      = 16;
  localparam int RD_MAX         = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic [4:0] {
    S_IDLE, S_START_REL, S_START_HIGH, S_START_LOW, S_START_HOLD,
    S_TX_HI, S_TX_LO, S_ACK_WAIT, S_ACK_HI, S_ACK_LO,
    S_RX_REL, S_RX_HI, S_RX_LO, S_MACK_HI, S_MACK_LO,
    S_STOP_LO, S_STOP_HI
  } bus_phase_e;

  typedef enum logic [2:0] {
    SEG_NONE, SEG_ADDR, SEG_REG, SEG_DATA, SEG_RADDR
  } xfer_seg_e;

  typedef enum int {
    LF_NONE, LF_START_LOW, LF_START_HIGH, LF_NOACK, LF_SLOW_ACK, LF_NOISE
  } line_fault_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_address;
    logic [7:0] data_byte;
    logic [4:0] length;
    logic       sda_in;
  } bus_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  i2cm_req_if req_if ();
  i2cm_res_if res_if ();

  i2c_master_register_access_unit #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_if     (req_if),
    .res_if     (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // bus controller mirror
  bus_phase_e  bus_ph;
  xfer_seg_e   seg;
  logic [3:0]  nbits;
  logic [7:0]  shifter;
  logic [4:0]  nbytes;
  logic [15:0] wait_cnt;
  logic [9:0]  ack_polls;
  logic [7:0]  wbuf [BUF_DEPTH];
  logic        rd_mode;
  logic [7:0]  reg_sel;
  logic [4:0]  xfer_len;
  logic        scl_q;
  logic        sda_q;
  logic [1:0]  stop_status;
  logic [7:0]  cfg_dev;
  logic [15:0] cfg_half;
  logic [9:0]  cfg_tmo;

  res_t bus_out_q [$];
  int   buf_written;
  int   n_items;
  int   n_fail;
  int   src_idle_pct;
  int   sink_idle_pct;
  bit   hold_request;
  int   idle_cycles;

  always #6 clk_i = ~clk_i;

  function automatic logic [15:0] half_eff();
    return (cfg_half == '0) ? 16'd1 : cfg_half;
  endfunction

  function automatic void go(bus_phase_e ph, logic scl, logic sda, logic [15:0] ticks);
    bus_ph   = ph;
    scl_q    = scl;
    sda_q    = sda;
    wait_cnt = ticks;
  endfunction

  function automatic void stop_with(logic [1:0] st);
    stop_status = st;
    go(S_STOP_LO, 1'b0, 1'b0, half_eff());
  endfunction

  function automatic void start_cond();
    go(S_START_REL, scl_q, 1'b1, half_eff());
  endfunction

  function automatic void load_tx(logic [7:0] b);
    shifter = b;
    nbits   = '0;
    go(S_TX_HI, 1'b1, b[7], half_eff());
  endfunction

  function automatic void load_rx();
    go(S_RX_REL, 1'b0, 1'b1, 16'((int'(half_eff()) + 4) / 5));
  endfunction

  function automatic void data_or_stop();
    if (nbytes < xfer_len) begin
      seg = SEG_DATA;
      load_tx(wbuf[nbytes[3:0]]);
    end else begin
      stop_with(STATUS_OK);
    end
  endfunction

  function automatic res_t i2c_step(bus_req_t r);
    res_t        o;
    logic [15:0] h;
    logic [9:0]  lim;
    logic [4:0]  n;
    o   = '0;
    h   = half_eff();
    lim = (cfg_tmo == '0) ? 10'd1 : cfg_tmo;
    if (r.func == FUNC_TICK) begin
      if (bus_ph == S_IDLE) begin
      end else if (bus_ph == S_ACK_WAIT) begin
        if (!r.sda_in) begin
          go(S_ACK_HI, 1'b1, 1'b1, h);
        end else begin
          ack_polls++;
          if (ack_polls >= lim) begin
            scl_q = 1'b0;
            stop_with(STATUS_NOACK);
          end
        end
      end else if (wait_cnt > 16'd1) begin
        wait_cnt--;
      end else begin
        case (bus_ph)
          S_START_REL: go(S_START_HIGH, 1'b1, 1'b1, h);
          S_START_HIGH: begin
            if (!r.sda_in) stop_with(STATUS_BUSERR);
            else go(S_START_LOW, 1'b1, 1'b0, h);
          end
          S_START_LOW: begin
            if (r.sda_in) stop_with(STATUS_BUSERR);
            else go(S_START_HOLD, 1'b0, 1'b0, h);
          end
          S_START_HOLD: begin
            if (rd_mode && seg == SEG_REG) begin
              seg = SEG_RADDR;
              load_tx(cfg_dev + 8'd1);
            end else begin
              seg = SEG_ADDR;
              load_tx(cfg_dev);
            end
          end
          S_TX_HI: go(S_TX_LO, 1'b0, sda_q, h);
          S_TX_LO: begin
            nbits++;
            if (nbits >= 4'd8) begin
              ack_polls = '0;
              go(S_ACK_WAIT, 1'b1, 1'b1, 16'd0);
            end else begin
              shifter = shifter << 1;
              go(S_TX_HI, 1'b1, shifter[7], h);
            end
          end
          S_ACK_HI: go(S_ACK_LO, 1'b0, 1'b1, h);
          S_ACK_LO: begin
            case (seg)
              SEG_ADDR: begin
                seg = SEG_REG;
                load_tx(reg_sel);
              end
              SEG_REG: begin
                if (rd_mode) start_cond();
                else data_or_stop();
              end
              SEG_DATA: begin
                nbytes++;
                data_or_stop();
              end
              default: begin
                nbytes = '0;
                load_rx();
              end
            endcase
          end
          S_RX_REL: begin
            nbits   = '0;
            shifter = '0;
            go(S_RX_HI, 1'b1, 1'b1, h);
          end
          S_RX_HI: begin
            shifter = {shifter[6:0], r.sda_in};
            nbits++;
            if (nbits >= 4'd8) begin
              o.read_byte  = shifter;
              o.read_valid = 1'b1;
              o.read_last  = (nbytes + 5'd1 >= xfer_len);
            end
            go(S_RX_LO, 1'b0, 1'b1, h);
          end
          S_RX_LO: begin
            if (nbits < 4'd8) go(S_RX_HI, 1'b1, 1'b1, h);
            else go(S_MACK_HI, 1'b1, (nbytes + 5'd1 >= xfer_len), h);
          end
          S_MACK_HI: go(S_MACK_LO, 1'b0, sda_q, h);
          S_MACK_LO: begin
            nbytes++;
            if (nbytes >= xfer_len) stop_with(STATUS_OK);
            else load_rx();
          end
          S_STOP_LO: go(S_STOP_HI, 1'b1, 1'b0, h);
          default: begin
            go(S_IDLE, 1'b1, 1'b1, 16'd0);
            o.done_res = 1'b1;
            o.status   = stop_status;
            nbytes     = '0;
            nbits      = '0;
            seg        = SEG_NONE;
          end
        endcase
      end
    end else if (bus_ph == S_IDLE) begin
      if (r.func == FUNC_PUSH) begin
        if (nbytes < BUF_DEPTH) begin
          wbuf[nbytes[3:0]] = r.data_byte;
          nbytes++;
          if (nbytes > buf_written) buf_written = nbytes;
        end
      end else begin
        rd_mode = (r.func == FUNC_READ);
        reg_sel = r.reg_address;
        n       = r.length;
        if (rd_mode) begin
          if (n == '0) n = 5'd1;
          if (n > RD_MAX) n = 5'(RD_MAX);
        end else if (n > BUF_DEPTH) begin
          n = 5'(BUF_DEPTH);
        end
        xfer_len  = n;
        nbytes    = '0;
        nbits     = '0;
        ack_polls = '0;
        seg       = SEG_NONE;
        start_cond();
      end
    end
    o.scl_out  = scl_q;
    o.sda_out  = sda_q;
    o.busy_res = (bus_ph != S_IDLE);
    return o;
  endfunction

  // target side of the bus as seen through sda_in
  function automatic logic pick_sda(line_fault_e f);
    if (f == LF_NOISE) return 1'($urandom);
    case (bus_ph)
      S_START_HIGH: return (f == LF_START_LOW) ? 1'b0 : 1'b1;
      S_START_LOW:  return (f == LF_START_HIGH) ? 1'b1 : 1'b0;
      S_ACK_WAIT: begin
        if (f == LF_NOACK) return 1'b1;
        if (f == LF_SLOW_ACK) return 1'($urandom);
        return 1'b0;
      end
      default: return 1'($urandom);
    endcase
  endfunction

  task automatic send_request(input bus_req_t it);
    int         gap;
    logic [4:0] eff;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    // never start a write that would reach buffer entries not yet filled
    if (it.func == FUNC_WRITE && bus_ph == S_IDLE) begin
      eff = (it.length > BUF_DEPTH) ? 5'(BUF_DEPTH) : it.length;
      if (eff > buf_written) it.length = 5'(buf_written);
    end
    if (bus_ph == S_IDLE || it.func == FUNC_TICK) n_items++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= it.func;
    req_if.reg_address <= it.reg_address;
    req_if.data_byte   <= it.data_byte;
    req_if.length      <= it.length;
    req_if.sda_in      <= it.sda_in;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    bus_out_q.push_back(i2c_step(it));
    @(negedge clk_i);
  endtask

  task automatic issue(input logic [1:0] f, input logic [7:0] ra, input logic [7:0] db,
                       input logic [4:0] len, input logic sda);
    bus_req_t r;
    r.func        = f;
    r.reg_address = ra;
    r.data_byte   = db;
    r.length      = len;
    r.sda_in      = sda;
    send_request(r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (bus_out_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    wait_drained();
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEV_ADDR: cfg_dev = val[7:0];
      CFG_HALF:     cfg_half = val;
      default:      cfg_tmo = val[9:0];
    endcase
  endtask

  // tick until the controller is idle again, with stray commands mixed in
  task automatic run_bus(input line_fault_e f, input int cmd_pct);
    while (bus_ph != S_IDLE) begin
      if ($urandom_range(99) < cmd_pct)
        issue(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
      else
        issue(FUNC_TICK, 8'($urandom), 8'($urandom), 5'($urandom), pick_sda(f));
    end
  endtask

  task automatic test_reset_config();
    issue(FUNC_READ, 8'h3C, 8'h00, 5'd1, 1'b1);
    run_bus(LF_NONE, 0);
  endtask

  task automatic test_idle_requests();
    issue(FUNC_TICK, 8'h00, 8'h00, 5'd0, 1'b0);
    issue(FUNC_TICK, 8'hFF, 8'hFF, 5'd31, 1'b1);
    for (int i = 0; i <= BUF_DEPTH; i++)
      issue(FUNC_PUSH, 8'($urandom), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
            5'd0, 1'b0);
  endtask

  task automatic test_write_saturation();
    write_cfg(CFG_HALF, 16'd1);
    write_cfg(CFG_DEV_ADDR, 16'd0);
    issue(FUNC_WRITE, 8'hFF, 8'h00, 5'd31, 1'b1);
    run_bus(LF_NONE, 10);
  endtask

  task automatic test_stale_write();
    issue(FUNC_PUSH, 8'h00, 8'($urandom), 5'd0, 1'b0);
    issue(FUNC_PUSH, 8'h00, 8'($urandom), 5'd0, 1'b1);
    issue(FUNC_WRITE, 8'h00, 8'h00, 5'd5, 1'b0);
    run_bus(LF_NONE, 0);
  endtask

  task automatic test_read_clamp();
    write_cfg(CFG_DEV_ADDR, 16'd254);
    issue(FUNC_READ, 8'h5A, 8'h00, 5'd0, 1'b0);
    run_bus(LF_NONE, 0);
    issue(FUNC_READ, 8'hA5, 8'h00, 5'd31, 1'b1);
    run_bus(LF_NONE, 5);
  endtask

  task automatic test_start_errors();
    issue(FUNC_WRITE, 8'h11, 8'h00, 5'd0, 1'b0);
    run_bus(LF_START_LOW, 0);
    issue(FUNC_READ, 8'h22, 8'h00, 5'd3, 1'b1);
    run_bus(LF_START_HIGH, 0);
  endtask

  task automatic test_ack_timeout();
    write_cfg(CFG_TIMEOUT, 16'd1);
    issue(FUNC_WRITE, 8'h33, 8'h00, 5'd1, 1'b0);
    run_bus(LF_NOACK, 0);
    write_cfg(CFG_TIMEOUT, 16'd0);
    write_cfg(CFG_HALF, 16'd0);
    issue(FUNC_WRITE, 8'h44, 8'h00, 5'd2, 1'b0);
    run_bus(LF_SLOW_ACK, 0);
    write_cfg(CFG_TIMEOUT, 16'd1023);
    issue(FUNC_READ, 8'h55, 8'h00, 5'd2, 1'b0);
    run_bus(LF_NOACK, 0);
    issue(FUNC_READ, 8'h66, 8'h00, 5'd2, 1'b0);
    run_bus(LF_SLOW_ACK, 0);
    write_cfg(CFG_TIMEOUT, 16'd8);
  endtask

  task automatic test_slow_half_period();
    write_cfg(CFG_HALF, 16'hFFFF);
    issue(FUNC_PUSH, 8'h00, 8'($urandom), 5'd0, 1'b0);
    issue(FUNC_TICK, 8'h00, 8'h00, 5'd0, 1'b1);
    issue(FUNC_PUSH, 8'h00, 8'($urandom), 5'd0, 1'b1);
    issue(FUNC_TICK, 8'h00, 8'h00, 5'd0, 1'b0);
    write_cfg(CFG_HALF, 16'd2);
  endtask

  task automatic test_output_backpressure();
    issue(FUNC_READ, 8'h77, 8'h00, 5'd4, 1'b0);
    hold_request = 1'b1;
    run_bus(LF_NONE, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n);
    int          stop_at;
    int          kind;
    int          pick;
    logic [4:0]  len;
    line_fault_e fault;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      kind  = $urandom_range(99);
      fault = ($urandom_range(99) < 80) ? LF_NONE : line_fault_e'($urandom_range(1, 5));
      pick  = $urandom_range(99);
      len   = (pick < 75) ? 5'($urandom_range(4)) :
              (pick < 95) ? 5'($urandom_range(5, 16)) : 5'($urandom_range(17, 31));
      if (kind < 10) begin
        repeat ($urandom_range(1, 8))
          issue(2'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
        run_bus(fault, 0);
      end else if (kind < 55) begin
        repeat ($urandom_range(5))
          issue(FUNC_PUSH, 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
        issue(FUNC_WRITE, 8'($urandom), 8'($urandom), len, 1'($urandom));
        run_bus(fault, 3);
      end else begin
        issue(FUNC_READ, 8'($urandom), 8'($urandom), len, 1'($urandom));
        run_bus(fault, 3);
      end
      if ($urandom_range(99) < 15) begin
        pick = $urandom_range(2);
        if (pick == 0)
          write_cfg(CFG_DEV_ADDR, 16'($urandom_range(127) * 2));
        else if (pick == 1)
          write_cfg(CFG_HALF, 16'($urandom_range(1, ($urandom_range(9) == 0) ? 8 : 2)));
        else
          write_cfg(CFG_TIMEOUT, 16'($urandom_range(1, 12)));
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (bus_out_q.size() == 0) begin
        $error("result with nothing outstanding");
        n_fail++;
      end else begin
        want = bus_out_q.pop_front();
        check_field("scl_out", want.scl_out, res_if.scl_out);
        check_field("sda_out", want.sda_out, res_if.sda_out);
        check_field("read_byte", want.read_byte, res_if.read_byte);
        check_field("read_valid", want.read_valid, res_if.read_valid);
        check_field("read_last", want.read_last, res_if.read_last);
        check_field("done_res", want.done_res, res_if.done_res);
        check_field("status", want.status, res_if.status);
        check_field("busy_res", want.busy_res, res_if.busy_res);
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_DEV_ADDR;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_TICK;
    req_if.reg_address = '0;
    req_if.data_byte   = '0;
    req_if.length      = '0;
    req_if.sda_in      = 1'b1;
    bus_ph             = S_IDLE;
    seg                = SEG_NONE;
    nbits              = '0;
    shifter            = '0;
    nbytes             = '0;
    wait_cnt           = '0;
    ack_polls          = '0;
    rd_mode            = 1'b0;
    reg_sel            = '0;
    xfer_len           = '0;
    scl_q              = 1'b1;
    sda_q              = 1'b1;
    stop_status        = STATUS_OK;
    cfg_dev            = 8'd180;
    cfg_half           = 16'd5;
    cfg_tmo            = 10'd500;
    buf_written        = 0;
    n_items            = 0;
    n_fail             = 0;
    hold_request       = 1'b0;
    idle_cycles        = 0;
    src_idle_pct       = 27;
    sink_idle_pct      = 74;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_idle_requests();
    test_write_saturation();
    test_stale_write();
    test_read_clamp();
    test_start_errors();
    test_ack_timeout();
    test_slow_half_period();
    test_random_traffic(400);

    src_idle_pct  = 74;
    sink_idle_pct = 27;
    test_random_traffic(400);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(400);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_if.sv
rtl/core/i2cm_core.sv
rtl/core/i2c_master_register_access_unit.sv
test/tb_i2c_master_register_access_unit.sv
